/* rtl/rsdn_pkg.sv */
// Shared constants for the RootSIFT descriptor normalizer.
`timescale 1ns / 1ps
`default_nettype none
package rsdn_pkg;
	localparam int ROOT_W = 17;
	localparam logic [ROOT_W-1:0] ONE_Q16 = 17'd65536;
endpackage
`default_nettype wire

/* rtl/rootsift_descriptor_normalizer.sv */
// Top level of the RootSIFT descriptor normalizer.
//
// Takes a descriptor of DESC_LEN signed elements as items of two (elem_a,
// elem_b), stores their magnitudes and accumulates their sum S. The item that
// completes the descriptor starts the compute phase: for each element a
// bit-serial divider forms |v|*2^32/S and a bit-serial square root gives r;
// r is stored and r*r summed. One more root gives the norm n, then for every
// element the divider forms r*65536/n, clamped to 65536, and results leave as
// pairs with last_pair on the final one. No item is accepted from the
// descriptor's last item until its last result has been taken; the compute runs
// serially through the shared divider and root unit, and an output stall holds it.
// A zero sum yields all-zero outputs.
`timescale 1ns / 1ps
`default_nettype none
module rootsift_descriptor_normalizer
	import rsdn_pkg::*;
#(
	parameter int DESC_LEN  = 128,
	parameter int ELEM_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [ELEM_BITS-1:0] elem_a,
	input  wire logic [ELEM_BITS-1:0] elem_b,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [ROOT_W-1:0]         root_a,
	output logic [ROOT_W-1:0]         root_b,
	output logic                      last_pair
);
	localparam int NPAIR = (DESC_LEN + 1) / 2;
	localparam int NEL   = 2 * NPAIR;
	localparam int IW    = $clog2(NEL);
	localparam int PW    = $clog2(NPAIR + 1);
	localparam int MAG_W = ELEM_BITS + 1;
	localparam int SUM_W = MAG_W + IW;
	localparam int DNUM  = MAG_W + 32;
	localparam int SQ_W  = 2 * ROOT_W + IW;
	localparam int RAD_W = 48;
	localparam int DIV_W = (SQ_W > SUM_W) ? SQ_W : SUM_W;

	typedef enum logic [3:0] {
		S_LOAD, S_DIV, S_DIVW, S_SQ, S_SQW, S_NRM, S_NRMW,
		S_OD, S_ODW, S_OUT
	} state_t;
	state_t state_q;

	logic [MAG_W-1:0]  mag_mem [NEL];
	logic [ROOT_W-1:0] root_mem [NEL];
	logic [MAG_W-1:0]  mag_rd_q;
	logic [ROOT_W-1:0] root_rd_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]   sq_q;
	logic [PW-1:0]     pcnt_q;
	logic [IW-1:0]     idx_q;
	logic [ROOT_W-1:0] norm_q;
	logic [ROOT_W-1:0] cur_q;
	logic              half_q;

	logic              div_start, div_done, sq_start, sq_done;
	logic [DNUM-1:0]   div_num;
	logic [DIV_W-1:0]  div_den;
	logic [DNUM-1:0]   div_q;
	logic [RAD_W-1:0]  sq_rad;
	logic [RAD_W/2-1:0] sq_root;

	logic [MAG_W-1:0]  mag_a, mag_b;
	logic [IW-1:0]     ia, ib;
	logic              in_acc;
	logic [ROOT_W-1:0] r_now, o_now;

	assign mag_a  = elem_a[ELEM_BITS-1] ? MAG_W'(-$signed({1'b1, elem_a}))
		: MAG_W'(elem_a);
	assign mag_b  = ((2 * int'(pcnt_q) + 1) >= DESC_LEN) ? '0
		: (elem_b[ELEM_BITS-1] ? MAG_W'(-$signed({1'b1, elem_b})) : MAG_W'(elem_b));
	assign ia     = IW'({pcnt_q, 1'b0});
	assign ib     = IW'({pcnt_q, 1'b1});
	assign in_stall = (state_q != S_LOAD);
	assign in_acc   = in_valid && !in_stall;
	assign r_now  = (sum_q == '0) ? '0 : ROOT_W'(sq_root);
	assign o_now  = (norm_q == '0) ? '0
		: ((div_q > DNUM'(ONE_Q16)) ? ONE_Q16 : ROOT_W'(div_q));

	// Shared divider: |v|*2^32 / S, then r*65536 / n; root unit: each quotient, then sum r*r.
	always_comb begin
		div_start = 1'b0;
		sq_start  = 1'b0;
		div_num   = '0;
		div_den   = '0;
		sq_rad    = '0;
		unique case (state_q)
			S_DIV: begin
				div_start = 1'b1;
				div_num   = {mag_rd_q, 32'd0};
				div_den   = DIV_W'(sum_q);
			end
			S_SQ: begin
				sq_start = 1'b1;
				sq_rad   = RAD_W'(div_q);
			end
			S_NRM: begin
				sq_start = 1'b1;
				sq_rad   = RAD_W'(sq_q);
			end
			S_OD: begin
				div_start = 1'b1;
				div_num   = DNUM'({root_rd_q, 16'd0});
				div_den   = DIV_W'(norm_q);
			end
			default: ;
		endcase
	end

	rsdn_divider #(.NUM_W(DNUM), .DEN_W(DIV_W)) u_div (
		.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quot(div_q)
	);
	rsdn_sqrt #(.RAD_W(RAD_W)) u_sqrt (
		.clk, .arst_n, .start(sq_start), .rad(sq_rad), .done(sq_done), .root(sq_root)
	);

	// Memories: magnitudes written at load, roots written after each root.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mag_mem[ia] <= mag_a;
			mag_mem[ib] <= mag_b;
		end
		if (state_q == S_SQW && sq_done)
			root_mem[idx_q] <= r_now;
		mag_rd_q  <= mag_mem[idx_q];
		root_rd_q <= root_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			sum_q     <= '0;
			sq_q      <= '0;
			pcnt_q    <= '0;
			idx_q     <= '0;
			norm_q    <= '0;
			half_q    <= 1'b0;
			cur_q     <= '0;
			out_valid <= 1'b0;
			root_a    <= '0;
			root_b    <= '0;
			last_pair <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						sum_q <= sum_q + SUM_W'(mag_a) + SUM_W'(mag_b);
						if (pcnt_q == PW'(NPAIR - 1)) begin
							pcnt_q  <= '0;
							idx_q   <= '0;
							sq_q    <= '0;
							state_q <= S_DIVW;
						end else begin
							pcnt_q <= pcnt_q + 1'b1;
						end
					end
				end
				// wait state so the registered memory read settles
				S_DIVW: state_q <= S_DIV;
				S_DIV:  state_q <= S_SQ;
				S_SQ: begin
					if (div_done) state_q <= S_SQW;
				end
				S_SQW: begin
					if (sq_done) begin
						sq_q <= sq_q + SQ_W'((2*ROOT_W)'(r_now) * (2*ROOT_W)'(r_now));
						if (idx_q == IW'(NEL - 1)) begin
							idx_q   <= '0;
							state_q <= S_NRM;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_DIVW;
						end
					end
				end
				S_NRM:  state_q <= S_NRMW;
				S_NRMW: begin
					if (sq_done) begin
						norm_q  <= ROOT_W'(sq_root);
						half_q  <= 1'b0;
						state_q <= S_ODW;
					end
				end
				S_ODW: state_q <= S_OD;
				S_OD:  state_q <= S_OUT;
				S_OUT: begin
					if (out_valid) begin
						if (!out_stall) begin
							out_valid <= 1'b0;
							if (last_pair) begin
								sum_q   <= '0;
								state_q <= S_LOAD;
							end else begin
								idx_q   <= idx_q + 1'b1;
								state_q <= S_ODW;
							end
						end
					end else if (div_done) begin
						if (!half_q) begin
							cur_q   <= o_now;
							half_q  <= 1'b1;
							idx_q   <= idx_q + 1'b1;
							state_q <= S_ODW;
						end else begin
							half_q    <= 1'b0;
							root_a    <= cur_q;
							root_b    <= (idx_q == IW'(NEL - 1) && (DESC_LEN % 2) == 1)
								? '0 : o_now;
							last_pair <= (idx_q == IW'(NEL - 1));
							out_valid <= 1'b1;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/rsdn_divider.sv */
// Bit-serial restoring divider: quotient of num by den, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rsdn_divider #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 40
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [NUM_W-1:0]      quot
);
	localparam int CW = $clog2(NUM_W + 1);
	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] sh_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] diff;

	assign trial = {rem_q[DEN_W-1:0], sh_q[NUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DEN_W+1]) begin
				rem_q <= diff[DEN_W:0];
				sh_q  <= {sh_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				sh_q  <= {sh_q[NUM_W-2:0], 1'b0};
			end
		end
	end
	assign quot = sh_q;
endmodule
`default_nettype wire

/* rtl/rsdn_sqrt.sv */
// Digit-serial integer square root: one result bit (two radicand bits) per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rsdn_sqrt #(
	parameter int RAD_W = 40
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [RAD_W-1:0]   rad,
	output logic                    done,
	output logic [RAD_W/2-1:0]      root
);
	localparam int RW = RAD_W / 2;
	localparam int CW = $clog2(RW + 1);
	logic [RAD_W-1:0] x_q;
	logic [RW+1:0]    rem_q;
	logic [RW-1:0]    res_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [RW+1:0]    trial;
	logic [RW+1:0]    tst;

	assign trial = {rem_q[RW-1:0], x_q[RAD_W-1:RAD_W-2]};
	assign tst   = {res_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= rad;
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[RAD_W-3:0], 2'b00};
			if (trial >= tst) begin
				rem_q <= trial - tst;
				res_q <= {res_q[RW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				res_q <= {res_q[RW-2:0], 1'b0};
			end
		end
	end
	assign root = res_q;
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the RootSIFT descriptor normalizer.
`timescale 1ns / 1ps
module tb_top;
	import rsdn_pkg::*;

	localparam int NUM_ELEMS = 128;
	localparam int NUM_PAIRS = NUM_ELEMS / 2;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 10;

	// Kinds of descriptor content
	typedef enum int {
		DESC_ZERO,
		DESC_EXTREME,
		DESC_FULL,
		DESC_SMALL,
		DESC_SPARSE
	} desc_kind_t;

	typedef struct packed {
		logic [15:0] a;
		logic [15:0] b;
	} elem_pair_t;

	typedef struct packed {
		logic [ROOT_W-1:0] a;
		logic [ROOT_W-1:0] b;
		logic              last;
	} root_pair_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [15:0]       elem_a = '0;
	logic [15:0]       elem_b = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [ROOT_W-1:0] root_a;
	logic [ROOT_W-1:0] root_b;
	logic              last_pair;

	elem_pair_t pending_pairs[$];
	root_pair_t expected_roots[$];

	// Predictor state: magnitudes of the descriptor being collected
	logic [16:0] desc_mags[NUM_ELEMS];
	longint unsigned mag_sum = 0;
	int pairs_seen = 0;

	int send_idle = 23;
	int recv_idle = 55;
	bit hold_armed = 1'b0;
	int hold_left = 0;
	int errors = 0;
	int cycles = 0;

	rootsift_descriptor_normalizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.elem_a    (elem_a),
		.elem_b    (elem_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.root_a    (root_a),
		.root_b    (root_b),
		.last_pair (last_pair)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [16:0] magnitude_of(logic [15:0] v);
		int sv;
		sv = $signed(v);
		return (sv < 0) ? 17'(-sv) : 17'(sv);
	endfunction

	// Take one accepted item; on the last item of a descriptor, compute all roots.
	task automatic take_pair(logic [15:0] a, logic [15:0] b);
		longint unsigned roots[NUM_ELEMS];
		longint unsigned sq_sum;
		longint unsigned norm;
		longint unsigned v;
		root_pair_t rp;
		logic [ROOT_W-1:0] outs[2];
		desc_mags[2*pairs_seen]     = magnitude_of(a);
		desc_mags[2*pairs_seen + 1] = magnitude_of(b);
		mag_sum += magnitude_of(a) + magnitude_of(b);
		pairs_seen++;
		if (pairs_seen < NUM_PAIRS)
			return;
		sq_sum = 0;
		for (int k = 0; k < NUM_ELEMS; k++) begin
			roots[k] = 0;
			if (mag_sum != 0)
				roots[k] = int_sqrt((longint'(desc_mags[k]) << 32) / mag_sum);
			sq_sum += roots[k] * roots[k];
		end
		norm = int_sqrt(sq_sum);
		for (int k = 0; k < NUM_PAIRS; k++) begin
			for (int j = 0; j < 2; j++) begin
				v = 0;
				if (norm != 0) begin
					v = (roots[2*k + j] * 65536) / norm;
					if (v > ONE_Q16)
						v = ONE_Q16;
				end
				outs[j] = v[ROOT_W-1:0];
			end
			rp.a = outs[0];
			rp.b = outs[1];
			rp.last = (k == NUM_PAIRS - 1);
			expected_roots.insert(expected_roots.size(), rp);
		end
		mag_sum = 0;
		pairs_seen = 0;
	endtask

	function automatic logic [15:0] make_elem(desc_kind_t kind, int idx);
		logic [15:0] e;
		case (kind)
			DESC_ZERO: begin
				e = '0;
			end
			DESC_EXTREME: begin
				case (idx % 6)
					0: e = 16'h8000;
					1: e = 16'h7fff;
					2: e = 16'h0000;
					3: e = 16'h0001;
					4: e = 16'hffff;
					default: e = 16'h8001;
				endcase
			end
			DESC_FULL: begin
				e = 16'($urandom);
			end
			DESC_SMALL: begin
				e = 16'($signed($urandom_range(30)) - 15);
			end
			default: begin
				// mostly zero; the rest split between 16'h8000 and random values
				if ($urandom_range(9) == 0)
					e = $urandom_range(1) ? 16'h8000 : 16'($urandom);
				else
					e = '0;
			end
		endcase
		return e;
	endfunction

	task automatic queue_descriptor(desc_kind_t kind);
		elem_pair_t p;
		for (int i = 0; i < NUM_PAIRS; i++) begin
			p.a = make_elem(kind, 2*i);
			p.b = make_elem(kind, 2*i + 1);
			pending_pairs.insert(pending_pairs.size(), p);
		end
	endtask

	task automatic drain;
		while (pending_pairs.size() != 0 || in_valid || expected_roots.size() != 0)
			@(posedge clk);
	endtask

	// Driver: advance to a new item only once the current one is taken; hold it while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				take_pair(elem_a, elem_b);
			if (!in_valid || !in_stall) begin
				if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle) begin
					elem_pair_t p;
					p = pending_pairs.pop_front();
					elem_a <= p.a;
					elem_b <= p.b;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Hold-off counter: start a long stretch at the first result once armed.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_armed && out_valid) begin
			hold_armed <= 1'b0;
			hold_left <= HOLD_CYCLES;
		end
	end

	// Monitor: check each taken result against the oldest expectation; drive out_stall, high during a hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_roots.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected result a=%0d b=%0d last=%0b",
							root_a, root_b, last_pair);
				end else begin
					root_pair_t e;
					e = expected_roots.pop_front();
					if (e.a !== root_a || e.b !== root_b || e.last !== last_pair) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("mismatch: expected a=%0d b=%0d last=%0b, got a=%0d b=%0d last=%0b",
								e.a, e.b, e.last, root_a, root_b, last_pair);
					end
				end
			end
			if (hold_left > 0)
				out_stall <= 1'b1;
			else
				out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero sum
		queue_descriptor(DESC_ZERO);
		drain();

		// Swap who idles more; extremes incl. most negative value
		send_idle = 55;
		recv_idle = 23;
		queue_descriptor(DESC_EXTREME);
		while (pending_pairs.size() != 0 || in_valid
			|| expected_roots.size() > NUM_PAIRS / 2)
			@(posedge clk);

		// No idling; hold off the receiver while the sender keeps offering items
		send_idle = 0;
		recv_idle = 0;
		hold_armed = 1'b1;
		queue_descriptor(DESC_FULL);
		drain();

		repeat (200) @(posedge clk);
		errors += expected_roots.size();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

/* filelist.f */
rtl/rsdn_pkg.sv
rtl/rsdn_divider.sv
rtl/rsdn_sqrt.sv
rtl/rootsift_descriptor_normalizer.sv
tb/tb_top.sv
